@@ design/assert_macros.svh @@
// Assertion macros shared by the lookup table RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ design/lpm_pkg.sv @@
// Types and constants for the longest-prefix-match table.
`timescale 1ns / 1ps

package lpm_pkg;

  // Width of a stored prefix length
  localparam int LEN_W = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_HIT     = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_TOOLONG = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [31:0]      search_key;
    logic [LEN_W-1:0] prefix_bits;
    logic [31:0]      entry_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
  } out_t;

endpackage

@@ design/lpm_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module lpm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/longest_prefix_match_table_core.sv @@
// Top level of the longest-prefix-match table: control, scan and result register.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation per transfer: insert, delete,
//   exact get or longest prefix lookup. out_valid/out_ready/out_data return
//   exactly one status and value per operation, in order.
//   Each operation scans every entry of the table memory, one entry per cycle
//   through its single read port, whose read is registered, then does the
//   write-back and loads the result register. The next operation can be taken
//   together with the result transfer of the previous one, so the block works
//   on one operation at a time. An insert, delete or get whose length exceeds
//   the key width skips the scan and answers in the next cycle.
//   After reset the valid memory is swept clear, one entry per cycle; in_ready
//   stays low meanwhile.
//   A stalled receiver holds the result in the output register; a new item is
//   taken only when that register is empty or being emptied.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module longest_prefix_match_table_core #(
  parameter int KEY_BYTES  = 4,
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lpm_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output lpm_pkg::out_t out_data
);

  localparam int BYTE_BITS = 8;
  localparam int KEY_BITS  = KEY_BYTES * BYTE_BITS;
  localparam int LEN_W     = lpm_pkg::LEN_W;
  localparam int ADDR_W    = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int ENT_W     = KEY_BITS + LEN_W + VALUE_BITS;

  // control registers
  lpm_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                hit_r, hit_nxt;
  logic                free_r, free_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload registers
  lpm_pkg::op_t        op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [ADDR_W-1:0]   free_idx_r, free_idx_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;
  logic [LEN_W-1:0]    best_len_r, best_len_nxt;
  lpm_pkg::out_t       out_data_r, out_data_nxt;

  // memory ports
  logic                vld_we, ent_we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic                vld_wdata;
  logic [ENT_W-1:0]    ent_wdata;
  logic                vld_rd;
  logic [ENT_W-1:0]    ent_rd;

  // input field conditioning
  logic [KEY_BITS+31:0]   key_wide;
  logic [VALUE_BITS+31:0] val_wide;
  logic [VALUE_BITS+31:0] res_wide;
  logic [KEY_BITS-1:0]    in_key;
  logic [KEY_BITS-1:0]    in_mask;
  logic                   in_toolong;
  lpm_pkg::op_t           in_op;

  // entry under evaluation
  logic [KEY_BITS-1:0]   e_pfx;
  logic [LEN_W-1:0]      e_len;
  logic [VALUE_BITS-1:0] e_val;
  logic [KEY_BITS-1:0]   e_mask;
  logic                  exact_m, lpm_m;

  assign key_wide   = {{KEY_BITS{1'b0}}, in_data.search_key};
  assign in_key     = key_wide[KEY_BITS-1:0];
  assign val_wide   = {{VALUE_BITS{1'b0}}, in_data.entry_value};
  assign res_wide   = {32'd0, hit_val_r};
  assign in_mask    = ~({KEY_BITS{1'b1}} >> in_data.prefix_bits);
  assign in_op      = lpm_pkg::op_t'(in_data.operation);
  assign in_toolong = {1'b0, in_data.prefix_bits} > (LEN_W + 1)'(KEY_BITS);

  assign e_pfx  = ent_rd[ENT_W-1 -: KEY_BITS];
  assign e_len  = ent_rd[VALUE_BITS +: LEN_W];
  assign e_val  = ent_rd[VALUE_BITS-1:0];
  assign e_mask = ~({KEY_BITS{1'b1}} >> e_len);

  // exact match for insert/delete/get, longer match for lookup
  assign exact_m = vld_rd && (e_len == len_r) && (e_pfx == key_r);
  assign lpm_m   = vld_rd && ((key_r & e_mask) == e_pfx) && (!hit_r || (e_len > best_len_r));

  // valid bits and entry words
  lpm_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (waddr),
    .wdata (vld_wdata),
    .raddr (raddr),
    .rdata (vld_rd)
  );

  lpm_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (waddr),
    .wdata (ent_wdata),
    .raddr (raddr),
    .rdata (ent_rd)
  );

  // next state, memory control and results
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = 1'b0;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    rd_idx_nxt    = rd_idx_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    hit_val_nxt   = hit_val_r;
    best_len_nxt  = best_len_r;
    out_data_nxt  = out_data_r;
    vld_we        = 1'b0;
    ent_we        = 1'b0;
    waddr         = hit_idx_r;
    vld_wdata     = 1'b0;
    ent_wdata     = {key_r, len_r, val_r};
    raddr         = cnt_r[ADDR_W-1:0];
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep the valid memory after reset
      lpm_pkg::S_CLEAR: begin
        vld_we = 1'b1;
        waddr  = cnt_r[ADDR_W-1:0];
        if (cnt_r == CNT_W'(ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = lpm_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      lpm_pkg::S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          op_nxt       = in_op;
          key_nxt      = (in_op == lpm_pkg::OP_LOOKUP) ? in_key : (in_key & in_mask);
          len_nxt      = in_data.prefix_bits;
          val_nxt      = val_wide[VALUE_BITS-1:0];
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
          best_len_nxt = '0;
          cnt_nxt      = '0;
          if (in_toolong && (in_op != lpm_pkg::OP_LOOKUP)) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.status       = lpm_pkg::STAT_TOOLONG;
            out_data_nxt.result_value = '0;
          end else begin
            state_nxt = lpm_pkg::S_SCAN;
          end
        end
      end

      // issue one read per cycle, evaluate the entry that returns
      lpm_pkg::S_SCAN: begin
        rd_idx_nxt = cnt_r[ADDR_W-1:0];
        if (cnt_r == CNT_W'(ENTRIES)) begin
          state_nxt = lpm_pkg::S_DONE;
        end else begin
          rd_vld_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (op_r == lpm_pkg::OP_LOOKUP) begin
            if (lpm_m) begin
              hit_nxt      = 1'b1;
              hit_val_nxt  = e_val;
              best_len_nxt = e_len;
            end
          end else begin
            if (exact_m && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = rd_idx_r;
              hit_val_nxt = e_val;
            end
            if (!vld_rd && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = rd_idx_r;
            end
          end
        end
      end

      // write back and load the result
      lpm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = lpm_pkg::STAT_MISS;
          out_data_nxt.result_value = '0;
          state_nxt                 = lpm_pkg::S_IDLE;
          case (op_r)
            lpm_pkg::OP_INSERT: begin
              if (hit_r) begin
                ent_we              = 1'b1;
                out_data_nxt.status = lpm_pkg::STAT_HIT;
              end else if (free_r) begin
                ent_we    = 1'b1;
                vld_we    = 1'b1;
                vld_wdata = 1'b1;
                waddr     = free_idx_r;
              end else begin
                out_data_nxt.status = lpm_pkg::STAT_FULL;
              end
            end
            lpm_pkg::OP_DELETE: begin
              if (hit_r) begin
                vld_we              = 1'b1;
                out_data_nxt.status = lpm_pkg::STAT_HIT;
              end
            end
            default: begin
              // get and lookup report the stored value on a hit
              if (hit_r) begin
                out_data_nxt.status       = lpm_pkg::STAT_HIT;
                out_data_nxt.result_value = res_wide[31:0];
              end
            end
          endcase
        end
      end

      default: begin
        state_nxt = lpm_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpm_pkg::S_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    len_r      <= len_nxt;
    val_r      <= val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    best_len_r <= best_len_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // memories are written only by the sweep or the write-back step
  `ASSERT_NEVER(a_write_phase, (vld_we || ent_we) && (state_r != lpm_pkg::S_CLEAR) && (state_r != lpm_pkg::S_DONE))

  // returned read data only follows a scan cycle
  `ASSERT_IMPLIES(a_read_in_scan, rd_vld_r, $past(state_r) == lpm_pkg::S_SCAN)

  // a slot is marked valid only by an insert of an absent prefix
  `ASSERT_IMPLIES(a_set_valid, vld_we && vld_wdata, (state_r == lpm_pkg::S_DONE) && (op_r == lpm_pkg::OP_INSERT) && !hit_r && free_r)

  // an over-long insert, delete or get answers in the next cycle without a scan
  `ASSERT_NEXT(a_toolong, in_valid && in_ready && in_toolong && (in_op != lpm_pkg::OP_LOOKUP), out_valid && (out_data.status == lpm_pkg::STAT_TOOLONG) && (state_r == lpm_pkg::S_IDLE))

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the longest-prefix-match table: directed rows, then random phases.
`timescale 1ns / 1ps

module tb;

  localparam int KEY_W       = 32;
  localparam int TBL_ENTRIES = 64;
  localparam int DRAIN_WAIT  = 150;
  localparam int LEN_W       = lpm_pkg::LEN_W;

  typedef enum int {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIXED
  } gen_mode_t;

  typedef struct {
    lpm_pkg::in_t  item;
    bit            typed;
    lpm_pkg::out_t res;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  lpm_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  lpm_pkg::out_t out_data;

  // Shadow copy of the table contents
  logic             tbl_valid  [TBL_ENTRIES];
  logic [31:0]      tbl_prefix [TBL_ENTRIES];
  logic [LEN_W-1:0] tbl_len    [TBL_ENTRIES];
  logic [31:0]      tbl_value  [TBL_ENTRIES];

  lpm_pkg::out_t pending_results[$];
  dir_row_t      dir_rows[$];
  int            fail_count = 0;
  bit            no_idle = 0;

  longest_prefix_match_table_core #(
    .KEY_BYTES (4),
    .ENTRIES   (TBL_ENTRIES),
    .VALUE_BITS(32)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  // Top len bits of a key set
  function automatic logic [31:0] prefix_mask(int unsigned len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (KEY_W - len);
  endfunction

  function automatic int count_valid();
    int n;
    n = 0;
    for (int i = 0; i < TBL_ENTRIES; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  // Random occupied slot, or -1 when the table is empty
  function automatic int pick_slot();
    int idx[$];
    for (int i = 0; i < TBL_ENTRIES; i++) if (tbl_valid[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  // Computes the answer to one operation and applies it to the shadow table
  function automatic lpm_pkg::out_t lpm_predict(lpm_pkg::in_t it);
    lpm_pkg::out_t r;
    int            best;
    int            hit;
    int            free_idx;
    int unsigned   len;
    logic [31:0]   pfx;
    r.status       = lpm_pkg::STAT_MISS;
    r.result_value = '0;
    len            = it.prefix_bits;
    best           = -1;
    hit            = -1;
    free_idx       = -1;
    if (it.operation == lpm_pkg::OP_LOOKUP) begin
      for (int i = 0; i < TBL_ENTRIES; i++) begin
        if (tbl_valid[i] && (it.search_key & prefix_mask(tbl_len[i])) == tbl_prefix[i] &&
            (best < 0 || tbl_len[i] > tbl_len[best]))
          best = i;
      end
      if (best >= 0) begin
        r.status       = lpm_pkg::STAT_HIT;
        r.result_value = tbl_value[best];
      end
    end else if (len > KEY_W) begin
      r.status = lpm_pkg::STAT_TOOLONG;
    end else begin
      pfx = it.search_key & prefix_mask(len);
      for (int i = 0; i < TBL_ENTRIES; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_len[i] == len && tbl_prefix[i] == pfx) hit = i;
        if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
      end
      case (it.operation)
        lpm_pkg::OP_INSERT: begin
          if (hit >= 0) begin
            tbl_value[hit] = it.entry_value;
            r.status       = lpm_pkg::STAT_HIT;
          end else if (free_idx < 0) begin
            r.status = lpm_pkg::STAT_FULL;
          end else begin
            tbl_valid[free_idx]  = 1'b1;
            tbl_prefix[free_idx] = pfx;
            tbl_len[free_idx]    = LEN_W'(len);
            tbl_value[free_idx]  = it.entry_value;
          end
        end
        lpm_pkg::OP_DELETE: begin
          if (hit >= 0) begin
            tbl_valid[hit] = 1'b0;
            r.status       = lpm_pkg::STAT_HIT;
          end
        end
        default: begin
          if (hit >= 0) begin
            r.status       = lpm_pkg::STAT_HIT;
            r.result_value = tbl_value[hit];
          end
        end
      endcase
    end
    return r;
  endfunction

  // Random key, often under one of a few shared top bytes so prefixes nest
  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    k = $urandom();
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: k[31:24] = 8'h00;
        1: k[31:24] = 8'h0A;
        2: k[31:24] = 8'hC0;
        default: k[31:24] = 8'hFF;
      endcase
    end
    return k;
  endfunction

  function automatic lpm_pkg::in_t make_op(gen_mode_t mode);
    lpm_pkg::in_t it;
    int           r;
    int           slot;
    int unsigned  len;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_FILL:  it.operation = (r < 85) ? lpm_pkg::OP_INSERT : 2'($urandom_range(0, 3));
      GEN_DRAIN: it.operation = (r < 85) ? lpm_pkg::OP_DELETE : 2'($urandom_range(0, 3));
      default:   it.operation = 2'($urandom_range(0, 3));
    endcase
    it.entry_value = $urandom();
    r = $urandom_range(0, 19);
    if (r == 0) it.entry_value = '0;
    else if (r == 1) it.entry_value = '1;
    slot = pick_slot();
    r    = $urandom_range(0, 99);
    if (it.operation == lpm_pkg::OP_LOOKUP) begin
      // length field is don't-care here
      it.prefix_bits = LEN_W'($urandom_range(0, 63));
      if (slot >= 0 && r < 70)
        it.search_key = tbl_prefix[slot] | ($urandom() & ~prefix_mask(tbl_len[slot]));
      else
        it.search_key = fresh_key();
    end else if (r < 8) begin
      it.prefix_bits = LEN_W'($urandom_range(KEY_W + 1, 63));
      it.search_key  = $urandom();
    end else if (slot >= 0 && r < 60 && mode != GEN_FILL) begin
      // stored prefix with junk below its length
      it.prefix_bits = tbl_len[slot];
      it.search_key  = tbl_prefix[slot] | ($urandom() & ~prefix_mask(tbl_len[slot]));
    end else begin
      if (mode == GEN_FILL) len = $urandom_range(12, KEY_W);
      else if ($urandom_range(0, 1)) len = $urandom_range(0, KEY_W);
      else len = 8 * $urandom_range(0, 4);
      it.prefix_bits = LEN_W'(len);
      it.search_key  = fresh_key();
    end
    return it;
  endfunction

  function automatic void add_row(lpm_pkg::op_t op, logic [31:0] key, int unsigned len,
                                  logic [31:0] val, bit typed, lpm_pkg::status_t st,
                                  logic [31:0] rv);
    dir_row_t row;
    row.item.operation    = op;
    row.item.search_key   = key;
    row.item.prefix_bits  = LEN_W'(len);
    row.item.entry_value  = val;
    row.typed             = typed;
    row.res.status        = st;
    row.res.result_value  = rv;
    dir_rows.push_back(row);
  endfunction

  // One input transfer; called at a falling edge, returns at a falling edge
  task automatic send_op(lpm_pkg::in_t it, bit typed, lpm_pkg::out_t typed_res);
    int            gap;
    lpm_pkg::out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = lpm_predict(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic send_random(gen_mode_t mode);
    lpm_pkg::out_t none;
    none = '0;
    send_op(make_op(mode), 1'b0, none);
  endtask

  // Sender pauses until every expected result has arrived
  task automatic wait_all_answered();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result receiver with random back-pressure
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    lpm_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, result_value %h",
               out_data.status, out_data.result_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %h, got %h", want.result_value,
                 out_data.result_value);
          fail_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_prefix[i] = '0;
      tbl_len[i]    = '0;
      tbl_value[i]  = '0;
    end

    // empty table, zero-length and full-length prefixes, key bits under the length,
    // replace, over-long lengths, deletes
    add_row(lpm_pkg::OP_LOOKUP, 32'h0000_0000,  0, 32'h0,         1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_GET,    32'hFFFF_FFFF, 32, 32'h0,         1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_DELETE, 32'h0000_0000,  0, 32'h0,         1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_INSERT, 32'hFFFF_FFFF,  0, 32'hFFFF_FFFF, 1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'h1234_5678,  0, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'hFFFF_FFFF);
    add_row(lpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 32, 32'h0,         1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF,  0, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'hFFFF_FFFE,  0, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'hFFFF_FFFF);
    add_row(lpm_pkg::OP_INSERT, 32'hAB00_0000,  8, 32'h1111_1111, 1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_INSERT, 32'hABCD_EF01,  8, 32'h2222_2222, 1, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_GET,    32'hAB12_3456,  8, 32'hFFFF_FFFF, 1, lpm_pkg::STAT_HIT,
            32'h2222_2222);
    add_row(lpm_pkg::OP_LOOKUP, 32'hAB99_8877, 63, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'h2222_2222);
    add_row(lpm_pkg::OP_INSERT, 32'h1234_5678, 33, 32'h5,         1, lpm_pkg::STAT_TOOLONG,
            32'h0);
    add_row(lpm_pkg::OP_GET,    32'h0000_0000, 63, 32'h0,         1, lpm_pkg::STAT_TOOLONG,
            32'h0);
    add_row(lpm_pkg::OP_DELETE, 32'hFFFF_FFFF, 40, 32'h0,         1, lpm_pkg::STAT_TOOLONG,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'hAB00_0000, 33, 32'h0,         0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_INSERT, 32'hAB80_0000,  9, 32'h3333_3333, 0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'hABFF_FFFF,  0, 32'h0,         0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_DELETE, 32'hAB00_0000,  8, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_GET,    32'hAB00_0000,  8, 32'h0,         1, lpm_pkg::STAT_MISS,
            32'h0);
    add_row(lpm_pkg::OP_LOOKUP, 32'hAB7F_FFFF,  0, 32'h0,         0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_INSERT, 32'h0000_0000,  1, 32'h5A5A_5A5A, 0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_DELETE, 32'h7FFF_FFFF,  1, 32'h0,         0, lpm_pkg::STAT_HIT,
            32'h0);
    add_row(lpm_pkg::OP_GET,    32'hFFFF_FFFF, 32, 32'h0,         1, lpm_pkg::STAT_HIT,
            32'h0);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_op(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    wait_all_answered();

    // fill to capacity, then push past it
    n = 0;
    while (count_valid() < TBL_ENTRIES && n < 400) begin
      send_random(GEN_FILL);
      n++;
    end
    repeat (20) send_random(GEN_FILL);
    wait_all_answered();

    // traffic against a full table
    repeat (200) send_random(GEN_MIXED);
    wait_all_answered();

    // empty it again
    n = 0;
    while (count_valid() > 0 && n < 300) begin
      send_random(GEN_DRAIN);
      n++;
    end
    wait_all_answered();

    // general traffic; one phase with no idling on either side
    for (int p = 0; p < 5; p++) begin
      no_idle = (p == 2);
      repeat (210) send_random(GEN_MIXED);
      in_valid <= 1'b0;
      wait_all_answered();
      @(negedge clk);
    end
    no_idle = 0;

    in_valid <= 1'b0;
    wait_all_answered();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
